// ===== rtl/tach_pkg.sv =====
// ----------------------------------------------------------------------------
// tach_pkg
// Shared types and constants for the windowed tachometer.
// ----------------------------------------------------------------------------
package tach_pkg;

  localparam int unsigned US_PER_MINUTE = 32'd60000000;
  localparam logic [15:0] SPEED_MAX     = 16'hFFFF;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] stamp_us;
  } tach_in_t;

  typedef struct packed {
    logic [15:0] speed_rpm;
    logic        drive_enable;
  } tach_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_POST
  } tach_state_t;

endpackage

// ===== rtl/tach_ring.sv =====
// ----------------------------------------------------------------------------
// tach_ring
// Ring of the last edge stamps with a rotating slot pointer; an entry
// never written reads as zero (empty).
// ----------------------------------------------------------------------------
module tach_ring #(
  parameter int WINDOW_EDGES = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [31:0] wr_stamp,
  output logic [31:0] rd_stamp
);

  localparam int SW = (WINDOW_EDGES > 1) ? $clog2(WINDOW_EDGES) : 1;

  logic [31:0]             stamp_r [WINDOW_EDGES];
  logic [WINDOW_EDGES-1:0] valid_r;
  logic [WINDOW_EDGES-1:0] valid_nxt;
  logic [SW-1:0]           slot_r;
  logic [SW-1:0]           slot_nxt;
  logic [31:0]             rd_r;

  assign rd_stamp = rd_r;

  always_comb begin
    valid_nxt = valid_r;
    slot_nxt  = slot_r;
    if (wr_en) begin
      valid_nxt[slot_r] = 1'b1;
      if (slot_r == SW'(WINDOW_EDGES - 1)) begin
        slot_nxt = '0;
      end else begin
        slot_nxt = slot_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      slot_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stamp_r[slot_r] <= wr_stamp;
    end
  end

  // hold the stamp of the slot the next edge compares with
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0;
    end else if (wr_en) begin
      if (slot_nxt == slot_r) begin
        rd_r <= wr_stamp;
      end else if (valid_r[slot_nxt]) begin
        rd_r <= stamp_r[slot_nxt];
      end else begin
        rd_r <= '0;
      end
    end
  end

endmodule

// ===== rtl/tach_div.sv =====
// ----------------------------------------------------------------------------
// tach_div
// Bit-serial restoring divider: constant dividend over a 32-bit span,
// one quotient bit per cycle, result saturated to 16 bits.
// ----------------------------------------------------------------------------
module tach_div #(
  parameter longint unsigned DIVIDEND = 64'd300000000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);

  localparam int DW = $clog2(DIVIDEND + 64'd1);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd_r;
  logic [DW-1:0] dvd_nxt;
  logic [DW-1:0] quo_r;
  logic [DW-1:0] quo_nxt;
  logic [31:0]   rem_r;
  logic [31:0]   rem_nxt;
  logic [31:0]   dsr_r;
  logic [31:0]   dsr_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic          busy_r;
  logic          busy_nxt;
  logic          done_r;
  logic          done_nxt;
  logic [32:0]   trial;
  logic [32:0]   diff;

  assign trial = {rem_r, dvd_r[DW-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = DW'(DIVIDEND);
      quo_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DW-2:0], 1'b0};
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = (|quo_r[DW-1:16]) ? tach_pkg::SPEED_MAX : quo_r[15:0];

endmodule

// ===== rtl/windowed_tachometer_with_stall_timeout.sv =====
// ----------------------------------------------------------------------------
// windowed_tachometer_with_stall_timeout
// Speed from the span over the last WINDOW_EDGES sensor edges, with a stall
// timeout on the tick command.
//
//   channel | direction | payload    | transfer when
//   in_     | input     | tach_in_t  | in_valid & in_ready
//   out_    | output    | tach_out_t | out_valid & out_ready
//
// A tick, an edge into an empty slot or a zero span goes from idle straight
// to the post state. An edge with a filled slot runs the bit-serial divider
// first, over DW bits, DW being the bit width of 60000000 * WINDOW_EDGES
// (29 at the default). Input is taken again as soon as the result sits in
// the output register. Reset empties the stamp ring at once.
// ----------------------------------------------------------------------------
module windowed_tachometer_with_stall_timeout #(
  parameter int WINDOW_EDGES = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tach_pkg::tach_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tach_pkg::tach_out_t out_data
);

  localparam longint unsigned DIVIDEND =
    64'(tach_pkg::US_PER_MINUTE) * 64'(WINDOW_EDGES);

  tach_pkg::tach_state_t state_r;
  tach_pkg::tach_state_t state_nxt;
  logic [15:0]           speed_r;
  logic [15:0]           speed_nxt;
  logic                  running_r;
  logic                  running_nxt;
  logic                  seen_r;
  logic                  seen_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  tach_pkg::tach_out_t   out_data_r;
  tach_pkg::tach_out_t   out_data_nxt;
  logic                  in_xfer;
  logic                  ring_wr;
  logic [31:0]           old_stamp;
  logic [31:0]           span;
  logic                  div_start;
  logic                  div_done;
  logic [15:0]           div_quotient;

  tach_ring #(
    .WINDOW_EDGES(WINDOW_EDGES)
  ) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (ring_wr),
    .wr_stamp (in_data.stamp_us),
    .rd_stamp (old_stamp)
  );

  tach_div #(
    .DIVIDEND(DIVIDEND)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign in_ready = (state_r == tach_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign span     = in_data.stamp_us - old_stamp;

  always_comb begin
    state_nxt     = state_r;
    speed_nxt     = speed_r;
    running_nxt   = running_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ring_wr       = 1'b0;
    div_start     = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      tach_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = tach_pkg::ST_POST;
          if (in_data.command == tach_pkg::CMD_EDGE) begin
            ring_wr     = 1'b1;
            running_nxt = 1'b1;
            seen_nxt    = 1'b1;
            if (old_stamp != 32'd0) begin
              if (span == 32'd0) begin
                speed_nxt = tach_pkg::SPEED_MAX;
              end else begin
                div_start = 1'b1;
                state_nxt = tach_pkg::ST_DIV;
              end
            end
          end else begin
            if (!seen_r) begin
              speed_nxt   = 16'd0;
              running_nxt = 1'b0;
            end
            seen_nxt = 1'b0;
          end
        end
      end
      tach_pkg::ST_DIV: begin
        if (div_done) begin
          speed_nxt = div_quotient;
          state_nxt = tach_pkg::ST_POST;
        end
      end
      tach_pkg::ST_POST: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.speed_rpm    = speed_r;
          out_data_nxt.drive_enable = running_r;
          state_nxt                 = tach_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tach_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tach_pkg::ST_IDLE;
      speed_r     <= 16'd0;
      running_r   <= 1'b0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      speed_r     <= speed_nxt;
      running_r   <= running_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
